>>> design/assert_macros.svh
// assertion helpers for the filter design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

>>> design/u8sf_pkg.sv
`timescale 1ns / 1ps

package u8sf_pkg;

    localparam int MAX_RESULTS  = 4;
    localparam int QUEUE_ADDR_W = 3;
    localparam int COUNT_W      = 3;

    // lead byte classes
    localparam logic [7:0] ASCII_MAX    = 8'h7F;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_CODE   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_CODE   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_CODE   = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_CODE    = 8'h80;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]              count;
        result_t [MAX_RESULTS-1:0]       item;
    } result_bundle_t;

endpackage

>>> design/u8sf_core.sv
`timescale 1ns / 1ps

module u8sf_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    message_last,
    output u8sf_pkg::result_bundle_t results
);
    import u8sf_pkg::*;

    logic [7:0] held_bytes_reg [3];
    logic [7:0] held_bytes_next [3];
    logic [2:0] expected_total_reg, expected_total_next;
    logic [1:0] held_count_reg, held_count_next;

    logic       seq_open;
    logic       is_cont;
    logic       consumed;
    logic       complete;
    logic       is_ascii;
    logic       is_lead2;
    logic       is_lead3;
    logic       is_lead4;
    logic [2:0] held_plus_one;
    logic [2:0] data_count;
    logic [2:0] final_count;
    logic [7:0] held_ext [4];

    assign seq_open      = (expected_total_reg != SEQ_NONE);
    assign is_cont       = ((data_byte & CONT_MASK) == CONT_CODE);
    assign consumed      = seq_open && is_cont;
    assign held_plus_one = {1'b0, held_count_reg} + 3'd1;
    assign complete      = consumed && (held_plus_one >= expected_total_reg);
    assign is_ascii      = (data_byte <= ASCII_MAX);
    assign is_lead2      = ((data_byte & LEAD2_MASK) == LEAD2_CODE);
    assign is_lead3      = ((data_byte & LEAD3_MASK) == LEAD3_CODE);
    assign is_lead4      = ((data_byte & LEAD4_MASK) == LEAD4_CODE);

    assign held_ext[0] = held_bytes_reg[0];
    assign held_ext[1] = held_bytes_reg[1];
    assign held_ext[2] = held_bytes_reg[2];
    assign held_ext[3] = 8'h00;

    // result list for this byte
    always_comb begin
        if (complete) begin
            data_count = held_plus_one;
        end else if (!consumed && is_ascii) begin
            data_count = 3'd1;
        end else begin
            data_count = 3'd0;
        end
        final_count = data_count;
        if (message_last && (data_count == 3'd0)) begin
            final_count = 3'd1;
        end

        results.count = final_count;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (complete) begin
                results.item[k].out_byte =
                    (3'(k) < {1'b0, held_count_reg}) ? held_ext[k] : data_byte;
            end else if (data_count != 3'd0) begin
                results.item[k].out_byte = data_byte;
            end else begin
                results.item[k].out_byte = 8'h00;
            end
            results.item[k].byte_valid  = (3'(k) < data_count);
            results.item[k].run_last    = (3'(k) == (final_count - 3'd1));
            results.item[k].message_end = message_last && (3'(k) == (final_count - 3'd1));
        end
    end

    // sequence state update
    always_comb begin
        held_bytes_next     = held_bytes_reg;
        expected_total_next = expected_total_reg;
        held_count_next     = held_count_reg;
        if (consumed) begin
            if (complete) begin
                expected_total_next = SEQ_NONE;
                held_count_next     = 2'd0;
            end else begin
                case (held_count_reg)
                    2'd0:    held_bytes_next[0] = data_byte;
                    2'd1:    held_bytes_next[1] = data_byte;
                    default: held_bytes_next[2] = data_byte;
                endcase
                held_count_next = held_count_reg + 2'd1;
            end
        end else begin
            expected_total_next = SEQ_NONE;
            held_count_next     = 2'd0;
            if (!is_ascii && is_lead2) begin
                held_bytes_next[0]  = data_byte;
                held_count_next     = 2'd1;
                expected_total_next = SEQ_LEN2;
            end else if (is_lead3) begin
                held_bytes_next[0]  = data_byte;
                held_count_next     = 2'd1;
                expected_total_next = SEQ_LEN3;
            end else if (is_lead4) begin
                held_bytes_next[0]  = data_byte;
                held_count_next     = 2'd1;
                expected_total_next = SEQ_LEN4;
            end
        end
        if (message_last) begin
            expected_total_next = SEQ_NONE;
            held_count_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_total_reg <= SEQ_NONE;
            held_count_reg     <= 2'd0;
        end else if (step) begin
            expected_total_reg <= expected_total_next;
            held_count_reg     <= held_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_bytes_reg <= held_bytes_next;
        end
    end

endmodule

>>> design/u8sf_queue.sv
`timescale 1ns / 1ps

module u8sf_queue #(
    parameter int ADDR_W = u8sf_pkg::QUEUE_ADDR_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  u8sf_pkg::result_bundle_t push_data,
    output logic                     room,
    output logic [ADDR_W:0]          level,
    output logic                     out_valid,
    input  logic                     out_ready,
    output u8sf_pkg::result_t        out_data
);
    import u8sf_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam logic [ADDR_W:0] ROOM_LIMIT = (ADDR_W + 1)'(DEPTH - MAX_RESULTS);

    result_t            mem_reg [DEPTH];
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W:0]    level_reg, level_next;
    logic [COUNT_W-1:0] push_count;
    logic               pop;

    assign push_count = push ? push_data.count : '0;
    assign pop        = out_valid && out_ready;
    assign out_valid  = (level_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign room       = (level_reg <= ROOM_LIMIT);
    assign level      = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + ADDR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + ADDR_W'(pop);
        level_next  = level_reg + (ADDR_W + 1)'(push_count) - (ADDR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (COUNT_W'(k) < push_count) begin
                mem_reg[wr_ptr_reg + ADDR_W'(k)] <= push_data.item[k];
            end
        end
    end

endmodule

>>> design/utf8_sequence_filter_top.sv
// path: accepted beats wait in the input register for queue room, then results enter the queue
// throughput: one input beat and one output beat per cycle, output only while m_tready is high;
//   a finished sequence leaves byte by byte from a result queue of 2**QUEUE_ADDR_W entries
// input stalls only while that queue holds more than depth minus four entries
// reset: aresetn synchronous active low; clears the open sequence and empties the queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_sequence_filter_top #(
    parameter int QUEUE_ADDR_W = u8sf_pkg::QUEUE_ADDR_W
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // message_last
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // message_end
);
    import u8sf_pkg::*;

    // input register stage
    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;

    logic           step;
    logic           room;
    logic [QUEUE_ADDR_W:0] level;
    result_bundle_t results;
    result_t        head;

    // a byte is processed once the queue can take a full four-byte burst
    assign step     = in_valid_reg && room;
    // the input stage refills in the same cycle it drains
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // sequence tracking and result list for the registered byte
    u8sf_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (in_byte_reg),
        .message_last (in_last_reg),
        .results      (results)
    );

    // result queue takes up to four results per cycle, gives one per cycle while m_tready is high
    u8sf_queue #(
        .ADDR_W (QUEUE_ADDR_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (results),
        .room      (room),
        .level     (level),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {7'd0, head.run_last, head.out_byte};
    assign m_tuser = head.byte_valid;
    assign m_tlast = head.message_end;

    // queue never overfills
    `ASSERT_IMP(a_level_bound, aclk, aresetn, 1'b1,
        level <= (QUEUE_ADDR_W + 1)'(1 << QUEUE_ADDR_W))
    // a processed byte never pushes more than one burst, and never into a full queue
    `ASSERT_IMP(a_push_fits, aclk, aresetn, step,
        (results.count <= COUNT_W'(MAX_RESULTS)) &&
        (level <= (QUEUE_ADDR_W + 1)'((1 << QUEUE_ADDR_W) - MAX_RESULTS)))
    // end of message always closes the run of its input byte
    `ASSERT_IMP(a_end_closes_run, aclk, aresetn, m_tvalid && m_tlast, m_tdata[8])
    // a processed last byte always yields at least one result
    `ASSERT_IMP(a_last_has_result, aclk, aresetn, step && in_last_reg,
        results.count != '0)

endmodule
